// ----- design/container_rewrite_decider_core_defines.svh -----
// Assertion macros shared by the container rewrite decider RTL.
`ifndef CONTAINER_REWRITE_DECIDER_CORE_DEFINES_SVH
`define CONTAINER_REWRITE_DECIDER_CORE_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define CRD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define CRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante at an edge implies cons at the next edge
`define CRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/crd_pkg.sv -----
// Package: types, codes and constants of the container rewrite decider.
`default_nettype none
package crd_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int ID_W    = 31;
	localparam int CHUNK_W = 20;
	localparam int TOTAL_W = 48;
	localparam int BYTES_W = 32;
	localparam int REFS_W  = 16;
	localparam int PCT_W   = 7;
	localparam int USED_W  = 7;
	localparam int RW_W    = 64;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DECIDE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CONTAINER_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_LIMIT    = 2'd2;

	localparam logic [BYTES_W-1:0] CONTAINER_SIZE_RST = 32'd4194304;
	localparam logic [PCT_W-1:0]   THRESHOLD_RST      = 7'd10;
	localparam logic [PCT_W-1:0]   RATIO_LIMIT_RST    = 7'd5;
	localparam logic [PCT_W-1:0]   PCT_MAX            = 7'd100;

	typedef struct packed {
		logic [1:0]         command;
		logic [ID_W-1:0]    old_container;
		logic [CHUNK_W-1:0] chunk_bytes;
		logic [TOTAL_W-1:0] total_size;
	} item_t;

	typedef struct packed {
		logic              keep;
		logic              not_found;
		logic              table_full;
		logic [USED_W-1:0] entries_used;
		logic [PCT_W-1:0]  threshold_pct;
	} result_t;

	// request into the entry table, one per cycle
	typedef struct packed {
		logic               vld;
		logic [1:0]         cmd;
		logic [ID_W-1:0]    id;
		logic [CHUNK_W-1:0] chunk;
	} tbl_req_t;

	// table status for the current request
	typedef struct packed {
		logic               hit;
		logic               full;
		logic [BYTES_W-1:0] bytes;
		logic [CNT_W-1:0]   used;
	} tbl_rsp_t;

	function automatic logic [USED_W-1:0] sat_used(input logic [CNT_W-1:0] n);
		logic [USED_W-1:0] r;
		r = (32'(n) > 127) ? 7'd127 : USED_W'(n);
		return r;
	endfunction

	function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
		logic [PCT_W-1:0] r;
		r = (v > PCT_MAX) ? PCT_MAX : v;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/crd_table.sv -----
// Entry table: parallel container match, slot allocation and per-entry counters.
`default_nettype none
`include "container_rewrite_decider_core_defines.svh"
module crd_table (
	input  logic              clk,
	input  logic              arst_n,
	input  crd_pkg::tbl_req_t req,
	output crd_pkg::tbl_rsp_t rsp
);
	import crd_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ID_W-1:0]        cont_q  [TABLE_DEPTH];
	logic [BYTES_W-1:0]     bytes_q [TABLE_DEPTH];
	logic [REFS_W-1:0]      refs_q  [TABLE_DEPTH];
	logic [CNT_W-1:0]       used_q;

	logic [TABLE_DEPTH-1:0] match;
	logic [TABLE_DEPTH-1:0] free_vec;
	logic [TABLE_DEPTH-1:0] free_oh;
	logic                   hit;
	logic                   any_free;
	logic [BYTES_W-1:0]     hit_bytes;
	logic [REFS_W-1:0]      hit_refs;
	logic                   do_ins;
	logic                   do_dec;
	logic                   do_clr;
	logic                   ins_hit;
	logic                   ins_new;
	logic                   dec_hit;
	logic                   dec_free;
	logic [CNT_W-1:0]       used_next;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_match
		assign match[i] = valid_q[i] && (cont_q[i] == req.id);
	end

	assign free_vec = ~valid_q;
	// lowest free slot, one-hot
	assign free_oh  = free_vec & (~free_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
	assign hit      = |match;
	assign any_free = |free_vec;

	// ids are unique among valid entries, so match is at most one-hot
	always_comb begin
		hit_bytes = '0;
		hit_refs  = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_bytes = hit_bytes | (bytes_q[i] & {BYTES_W{match[i]}});
			hit_refs  = hit_refs  | (refs_q[i]  & {REFS_W{match[i]}});
		end
	end

	assign do_ins   = req.vld && (req.cmd == CMD_INSERT);
	assign do_dec   = req.vld && (req.cmd == CMD_DECIDE);
	assign do_clr   = req.vld && (req.cmd == CMD_CLEAR);
	assign ins_hit  = do_ins && hit;
	assign ins_new  = do_ins && !hit && any_free;
	assign dec_hit  = do_dec && hit;
	assign dec_free = dec_hit && (hit_refs <= REFS_W'(1));

	always_comb begin
		used_next = used_q;
		if (do_clr) begin
			used_next = '0;
		end else if (ins_new) begin
			used_next = used_q + CNT_W'(1);
		end else if (dec_free) begin
			used_next = used_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else begin
			used_q <= used_next;
			if (do_clr) begin
				valid_q <= '0;
			end else if (ins_new) begin
				valid_q <= valid_q | free_oh;
			end else if (dec_free) begin
				valid_q <= valid_q & ~match;
			end
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [BYTES_W:0] sum;
		assign sum = {1'b0, bytes_q[i]} + (BYTES_W+1)'(req.chunk);

		always_ff @(posedge clk) begin
			if (ins_hit && match[i]) begin
				bytes_q[i] <= sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
				if (refs_q[i] != {REFS_W{1'b1}}) begin
					refs_q[i] <= refs_q[i] + REFS_W'(1);
				end
			end else if (ins_new && free_oh[i]) begin
				cont_q[i]  <= req.id;
				bytes_q[i] <= BYTES_W'(req.chunk);
				refs_q[i]  <= REFS_W'(1);
			end else if (dec_hit && match[i] && (refs_q[i] != '0)) begin
				refs_q[i] <= refs_q[i] - REFS_W'(1);
			end
		end
	end

	assign rsp.hit   = hit;
	assign rsp.full  = do_ins && !hit && !any_free;
	assign rsp.bytes = hit_bytes;
	assign rsp.used  = used_next;

	`CRD_ASSERT_ALWAYS(a_match_unique, $onehot0(match), "two entries hold one container")
	`CRD_ASSERT_ALWAYS(a_used_count, $countones(valid_q) == 32'(used_q), "fill count off")
	`CRD_ASSERT_IMPLY(a_full_real, rsp.full, &valid_q, "full flagged with a free slot")

endmodule
`default_nettype wire

// ----- design/container_rewrite_decider_core.sv -----
// Top level: container rewrite decider with threshold, ratio and result logic.
//
// Use: drive an item word on item and raise start; it is taken at the rising
// edge where start is high and busy is low. busy stays low, so one word can
// be taken every cycle. command selects insert (add chunk bytes to the
// container's entry), decide (keep or rewrite the chunk) or clear (empty the
// table); the unused code only reports status.
// Each taken word gives exactly one result word, shown on result for one
// cycle with done high, once the item has passed the capture registers and
// then the result registers. The receiver cannot stall; results are never
// held back.
// Throughput is one item per cycle: the 64-entry table matches all entries in
// parallel and every state update finishes in the cycle after capture.
// Configuration words (container size, initial threshold, ratio limit) come
// over cfg_valid/cfg_ready with cfg_index and cfg_data, while no item is in
// flight or being offered. Writing the initial threshold also reloads the
// live threshold.
// Reset clears the table, loads the default register values, sets the
// running threshold to 10, rewritten bytes to zero and the ratio flag to one.
`default_nettype none
`include "container_rewrite_decider_core_defines.svh"
module container_rewrite_decider_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  crd_pkg::item_t                    item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	output logic                              done,
	output crd_pkg::result_t                  result
);
	import crd_pkg::*;

	localparam int LHS_W   = BYTES_W + PCT_W;
	localparam int RHS_W   = PCT_W + TOTAL_W;
	localparam int RW100_W = RW_W + PCT_W;

	// configuration
	logic [BYTES_W-1:0] csize_q;
	logic [PCT_W-1:0]   rlim_q;

	// running state
	logic [PCT_W-1:0]   thr_q;
	logic [RW_W-1:0]    rw_q;
	logic               ratio_ok_q;

	// capture stage
	logic               vld_s1;
	item_t              item_s1;
	logic [RHS_W-1:0]   rhs_s1;
	logic               tzero_s1;

	// result
	logic               done_q;
	result_t            result_q;

	logic               accept;
	logic               cfg_wr;
	logic [RHS_W-1:0]   rhs;
	tbl_req_t           treq;
	tbl_rsp_t           trsp;

	logic               is_dec;
	logic               dec_hit;
	logic [LHS_W-1:0]   lhs;
	logic [LHS_W-1:0]   lim;
	logic               small_enough;
	logic               rewrite;
	logic               shrink;
	logic [PCT_W-1:0]   thr_next;
	logic [RW_W:0]      rw_sum;
	logic [RW_W-1:0]    rw_next;
	logic [RW100_W-1:0] rw100;
	logic               ratio_next;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	// no write while a word sits in capture or is offered, so rhs sees settled limits
	assign cfg_ready = !vld_s1 && !start;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// ratio limit * total, worked out on capture so the update cycle only compares
	assign rhs = RHS_W'(rlim_q) * RHS_W'(item.total_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1  <= item;
			rhs_s1   <= rhs;
			tzero_s1 <= (item.total_size == '0);
		end
	end

	assign treq.vld   = vld_s1;
	assign treq.cmd   = item_s1.command;
	assign treq.id    = item_s1.old_container;
	assign treq.chunk = item_s1.chunk_bytes;

	crd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (treq),
		.rsp    (trsp)
	);

	// decide: bytes*100 against size*threshold
	assign is_dec  = vld_s1 && (item_s1.command == CMD_DECIDE);
	assign dec_hit = is_dec && trsp.hit;
	assign lhs = LHS_W'({trsp.bytes, 6'b0}) + LHS_W'({trsp.bytes, 5'b0})
		+ LHS_W'({trsp.bytes, 2'b0});
	assign lim = LHS_W'(csize_q) * LHS_W'(thr_q);
	assign small_enough = (lhs <= lim);
	assign rewrite = dec_hit && small_enough && ratio_ok_q;
	assign shrink  = dec_hit && small_enough && !ratio_ok_q;

	always_comb begin
		thr_next = thr_q;
		if (rewrite) begin
			thr_next = sat_pct(thr_q + PCT_W'(1));
		end else if (shrink && (thr_q != '0)) begin
			thr_next = thr_q - PCT_W'(1);
		end
	end

	// rewritten bytes, saturating
	assign rw_sum  = {1'b0, rw_q} + (RW_W+1)'(trsp.bytes);
	assign rw_next = !rewrite ? rw_q : (rw_sum[RW_W] ? {RW_W{1'b1}} : rw_sum[RW_W-1:0]);

	// exact compare, so no separate overflow check on rw*100
	assign rw100 = RW100_W'({rw_next, 6'b0}) + RW100_W'({rw_next, 5'b0})
		+ RW100_W'({rw_next, 2'b0});
	assign ratio_next = !tzero_s1 && (rw100 <= RW100_W'(rhs_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q    <= CONTAINER_SIZE_RST;
			rlim_q     <= RATIO_LIMIT_RST;
			thr_q      <= sat_pct(THRESHOLD_RST);
			rw_q       <= '0;
			ratio_ok_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_CONTAINER_SIZE: csize_q <= cfg_data;
				REG_INIT_THRESHOLD: thr_q   <= sat_pct(cfg_data[PCT_W-1:0]);
				REG_RATIO_LIMIT:    rlim_q  <= cfg_data[PCT_W-1:0];
				default:            ;
			endcase
		end else if (dec_hit) begin
			thr_q      <= thr_next;
			rw_q       <= rw_next;
			ratio_ok_q <= ratio_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			result_q.keep          <= dec_hit && !rewrite;
			result_q.not_found     <= is_dec && !trsp.hit;
			result_q.table_full    <= trsp.full;
			result_q.entries_used  <= sat_used(trsp.used);
			result_q.threshold_pct <= thr_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`CRD_ASSERT_ALWAYS(a_thr_range, thr_q <= PCT_MAX, "threshold above 100")
	`CRD_ASSERT_NEXT(a_other_flags, vld_s1 && !is_dec, !result_q.keep && !result_q.not_found, "decide flags on a non-decide item")
	`CRD_ASSERT_NEXT(a_rw_grows, rewrite, rw_q >= $past(rw_q), "rewritten bytes went down")
	`CRD_ASSERT_IMPLY(a_no_cfg_busy, cfg_wr, !vld_s1, "config write with an item in flight")

endmodule
`default_nettype wire
